// File: src/wfa_pkg.sv
// ----------------------------------------------------------------------------
// wfa_pkg
// Shared types and constants of the worst-fit heap allocator.
// ----------------------------------------------------------------------------
package wfa_pkg;

  // block table geometry
  localparam int MAX_BLOCKS = 32;
  localparam int IDX_W      = 5;
  localparam int CNT_W      = 6;

  // heap geometry
  localparam logic [16:0] HEADER_BYTES = 17'd24;
  localparam logic [16:0] HEAP_BYTES   = 17'd65536;
  localparam logic [16:0] ADDR_SPACE   = 17'd65536;

  // size rounding
  localparam logic [15:0] MIN_ALLOC = 16'd16;

  // actions carried in tuser
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // status codes
  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_NO_MEM   = 2'd1;
  localparam logic [1:0] ST_BAD_ADDR = 2'd2;

  // one block table entry
  typedef struct packed {
    logic        used;
    logic [16:0] size;
    logic [15:0] start;
  } entry_t;

endpackage

// File: src/wfa_round.sv
// ----------------------------------------------------------------------------
// wfa_round
// Rounds an allocate request: zero stays zero, small sizes go to the minimum,
// everything else up to a multiple of 8.
// ----------------------------------------------------------------------------
module wfa_round (
  input  logic [15:0] req,
  output logic [16:0] size
);

  logic [16:0] up8;

  // add 7 and clear the low three bits
  assign up8 = ({1'b0, req} + 17'd7) & ~17'd7;

  always_comb begin
    if (req == 16'd0) begin
      size = 17'd0;
    end else if (req < wfa_pkg::MIN_ALLOC) begin
      size = {1'b0, wfa_pkg::MIN_ALLOC};
    end else begin
      size = up8;
    end
  end

endmodule

// File: src/worst_fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// worst_fit_heap_allocator
// Worst-fit allocator over an address-ordered block table held in RAM.
// ----------------------------------------------------------------------------
// One item at a time. An allocate walks the table once, one entry per cycle
// through the single RAM read port; a zero size skips the walk. A free walks
// the table the same way to find its block, then reads each neighbour and, for
// every merge, moves the later entries down one place, reading and then
// writing each entry. in_tready is low from an accepted beat until its result
// has been loaded into the output register; the output register lets the next
// beat in while a result waits.
module worst_fit_heap_allocator (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: heap_limit
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [16:0] cfg_data,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] request_size, [31:16] address
  input  logic        in_tuser,   // [0] action
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [15:0] result_address, [32:16] heap_top
  output logic [1:0]  out_tuser   // [1:0] status
);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_ALLOC, S_FREE, S_RIGHT, S_RIGHT_CHK, S_LEFT,
    S_LEFT_CHK, S_SH_RD, S_SH_WR, S_TAIL, S_OUT
  } state_t;

  localparam logic [wfa_pkg::CNT_W-1:0] CNT_MAX = wfa_pkg::CNT_W'(wfa_pkg::MAX_BLOCKS);

  state_t state_r, state_nxt, ret_r, ret_nxt;

  logic [16:0]               heap_limit_r;
  logic [wfa_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [16:0]               heap_end_r, heap_end_nxt;

  logic                      act_r, act_nxt;
  logic [16:0]               size_r, size_nxt;
  logic [15:0]               addr_r, addr_nxt;

  logic [wfa_pkg::CNT_W-1:0] scan_k_r, scan_k_nxt;
  logic                      pend_r, pend_nxt;
  logic [wfa_pkg::IDX_W-1:0] pend_idx_r, pend_idx_nxt;
  logic                      found_r, found_nxt;
  logic [wfa_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic [wfa_pkg::IDX_W-1:0] sh_j_r, sh_j_nxt;
  wfa_pkg::entry_t           cur_r, cur_nxt;

  logic [15:0]               res_addr_r, res_addr_nxt;
  logic [1:0]                res_status_r, res_status_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic [39:0]               out_data_r, out_data_nxt;
  logic [1:0]                out_user_r, out_user_nxt;

  // table RAM
  wfa_pkg::entry_t           mem [wfa_pkg::MAX_BLOCKS];
  wfa_pkg::entry_t           rd_r;
  logic [wfa_pkg::IDX_W-1:0] mem_ra;
  logic                      mem_we;
  logic [wfa_pkg::IDX_W-1:0] mem_wa;
  wfa_pkg::entry_t           mem_wd;

  logic [16:0]               req_size;
  logic [16:0]               eff_limit;
  logic [17:0]               need_top;
  logic [wfa_pkg::CNT_W-1:0] idx_ext;
  logic [wfa_pkg::CNT_W-1:0] sh_ext;
  logic [16:0]               rd_data_addr;

  wfa_round u_round (
    .req  (in_tdata[15:0]),
    .size (req_size)
  );

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // append limit and the top an append would reach
  assign eff_limit = (heap_limit_r > wfa_pkg::HEAP_BYTES) ? wfa_pkg::HEAP_BYTES : heap_limit_r;
  assign need_top  = {1'b0, heap_end_r} + {1'b0, wfa_pkg::HEADER_BYTES} + {1'b0, size_r};

  assign idx_ext      = {1'b0, idx_r};
  assign sh_ext       = {1'b0, sh_j_r};
  assign rd_data_addr = {1'b0, rd_r.start} + wfa_pkg::HEADER_BYTES;

  // ram ports
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_r <= mem[mem_ra];
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    ret_nxt        = ret_r;
    count_nxt      = count_r;
    heap_end_nxt   = heap_end_r;
    act_nxt        = act_r;
    size_nxt       = size_r;
    addr_nxt       = addr_r;
    scan_k_nxt     = scan_k_r;
    pend_nxt       = 1'b0;
    pend_idx_nxt   = pend_idx_r;
    found_nxt      = found_r;
    idx_nxt        = idx_r;
    sh_j_nxt       = sh_j_r;
    cur_nxt        = cur_r;
    res_addr_nxt   = res_addr_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    out_user_nxt   = out_user_r;
    mem_ra         = scan_k_r[wfa_pkg::IDX_W-1:0];
    mem_we         = 1'b0;
    mem_wa         = idx_r;
    mem_wd         = cur_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      // take a beat
      S_IDLE: begin
        if (in_tvalid) begin
          act_nxt        = in_tuser;
          size_nxt       = req_size;
          addr_nxt       = in_tdata[31:16];
          scan_k_nxt     = '0;
          found_nxt      = 1'b0;
          cur_nxt        = '0;
          res_addr_nxt   = 16'd0;
          res_status_nxt = wfa_pkg::ST_DONE;
          if (in_tuser == wfa_pkg::ACT_ALLOC && req_size == 17'd0) begin
            state_nxt = S_OUT;
          end else if (in_tuser == wfa_pkg::ACT_FREE && in_tdata[31:16] == 16'd0) begin
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      // walk the table one entry a cycle
      S_SCAN: begin
        if (scan_k_r < count_r) begin
          pend_nxt     = 1'b1;
          pend_idx_nxt = scan_k_r[wfa_pkg::IDX_W-1:0];
          scan_k_nxt   = scan_k_r + 1'b1;
        end
        if (pend_r) begin
          if (act_r == wfa_pkg::ACT_ALLOC) begin
            if (!rd_r.used && rd_r.size > cur_r.size) begin
              cur_nxt   = rd_r;
              idx_nxt   = pend_idx_r;
              found_nxt = 1'b1;
            end
          end else if (!found_r && rd_data_addr == {1'b0, addr_r}) begin
            cur_nxt      = rd_r;
            cur_nxt.used = 1'b0;
            idx_nxt      = pend_idx_r;
            found_nxt    = 1'b1;
          end
        end
        if (scan_k_r == count_r && !pend_r) begin
          state_nxt = (act_r == wfa_pkg::ACT_ALLOC) ? S_ALLOC : S_FREE;
        end
      end

      // reuse the largest free block, append, or report no memory
      S_ALLOC: begin
        state_nxt = S_OUT;
        if (found_r && size_r <= cur_r.size) begin
          mem_we        = 1'b1;
          mem_wa        = idx_r;
          mem_wd        = cur_r;
          mem_wd.used   = 1'b1;
          res_addr_nxt  = 16'(cur_r.start + wfa_pkg::HEADER_BYTES[15:0]);
        end else if (count_r >= CNT_MAX || need_top > {1'b0, eff_limit}) begin
          res_status_nxt = wfa_pkg::ST_NO_MEM;
        end else begin
          mem_we       = 1'b1;
          mem_wa       = count_r[wfa_pkg::IDX_W-1:0];
          mem_wd.used  = 1'b1;
          mem_wd.size  = size_r;
          mem_wd.start = heap_end_r[15:0];
          count_nxt    = count_r + 1'b1;
          heap_end_nxt = need_top[16:0];
          res_addr_nxt = 16'(heap_end_r[15:0] + wfa_pkg::HEADER_BYTES[15:0]);
        end
      end

      // free: found or not
      S_FREE: begin
        if (found_r) begin
          state_nxt = S_RIGHT;
        end else begin
          res_status_nxt = wfa_pkg::ST_BAD_ADDR;
          state_nxt      = S_OUT;
        end
      end

      // right neighbour
      S_RIGHT: begin
        if (idx_ext + 1'b1 < count_r) begin
          mem_ra    = idx_r + 1'b1;
          state_nxt = S_RIGHT_CHK;
        end else begin
          state_nxt = S_LEFT;
        end
      end

      S_RIGHT_CHK: begin
        if (!rd_r.used) begin
          cur_nxt.size = cur_r.size + wfa_pkg::HEADER_BYTES + rd_r.size;
          sh_j_nxt     = idx_r + 1'b1;
          ret_nxt      = S_LEFT;
          state_nxt    = S_SH_RD;
        end else begin
          state_nxt = S_LEFT;
        end
      end

      // left neighbour
      S_LEFT: begin
        if (idx_r != '0) begin
          mem_ra    = idx_r - 1'b1;
          state_nxt = S_LEFT_CHK;
        end else begin
          state_nxt = S_TAIL;
        end
      end

      S_LEFT_CHK: begin
        if (!rd_r.used) begin
          cur_nxt.start = rd_r.start;
          cur_nxt.size  = rd_r.size + wfa_pkg::HEADER_BYTES + cur_r.size;
          sh_j_nxt      = idx_r;
          idx_nxt       = idx_r - 1'b1;
          ret_nxt       = S_TAIL;
          state_nxt     = S_SH_RD;
        end else begin
          state_nxt = S_TAIL;
        end
      end

      // drop entry sh_j by moving the later ones down
      S_SH_RD: begin
        if (sh_ext + 1'b1 < count_r) begin
          mem_ra    = sh_j_r + 1'b1;
          state_nxt = S_SH_WR;
        end else begin
          count_nxt = count_r - 1'b1;
          state_nxt = ret_r;
        end
      end

      S_SH_WR: begin
        mem_we    = 1'b1;
        mem_wa    = sh_j_r;
        mem_wd    = rd_r;
        sh_j_nxt  = sh_j_r + 1'b1;
        state_nxt = S_SH_RD;
      end

      // free block at the end lowers the heap top; otherwise it is written back
      S_TAIL: begin
        if (idx_ext + 1'b1 == count_r) begin
          heap_end_nxt = {1'b0, cur_r.start};
          count_nxt    = count_r - 1'b1;
        end else begin
          mem_we = 1'b1;
          mem_wa = idx_r;
          mem_wd = cur_r;
        end
        state_nxt = S_OUT;
      end

      // load the output register
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {7'd0, heap_end_r, res_addr_r};
          out_user_nxt  = res_status_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      ret_r        <= S_IDLE;
      heap_limit_r <= 17'd65536;
      count_r      <= '0;
      heap_end_r   <= '0;
      pend_r       <= 1'b0;
      found_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      count_r     <= count_nxt;
      heap_end_r  <= heap_end_nxt;
      pend_r      <= pend_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        heap_limit_r <= cfg_data;
      end
    end
    act_r        <= act_nxt;
    size_r       <= size_nxt;
    addr_r       <= addr_nxt;
    scan_k_r     <= scan_k_nxt;
    pend_idx_r   <= pend_idx_nxt;
    idx_r        <= idx_nxt;
    sh_j_r       <= sh_j_nxt;
    cur_r        <= cur_nxt;
    res_addr_r   <= res_addr_nxt;
    res_status_r <= res_status_nxt;
    out_data_r   <= out_data_nxt;
    out_user_r   <= out_user_nxt;
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_MAX)
    else $error("block count past table depth");

  a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
    heap_end_r <= wfa_pkg::ADDR_SPACE)
    else $error("heap top past address space");

  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("ready while an item is in work");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_user_r == wfa_pkg::ST_DONE || out_user_r == wfa_pkg::ST_NO_MEM ||
                     out_user_r == wfa_pkg::ST_BAD_ADDR))
    else $error("undefined status code");

endmodule
